### hw/rtl/gps_heading_estimator_top_defines.svh
// ----------------------------------------------------------------------------
// GPS heading estimator: assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GPS_HEADING_ESTIMATOR_TOP_DEFINES_SVH
`define GPS_HEADING_ESTIMATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define GPSH_CHECK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gpsh check failed");
`define GPSH_CHECK_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("gpsh check failed");
`else
`define GPSH_CHECK(lbl, clk, rst_n, prop)
`define GPSH_CHECK_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/gpsh_pkg.sv
// ----------------------------------------------------------------------------
// gpsh_pkg
// Types, constants and the CORDIC angle table of the heading estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package gpsh_pkg;
	localparam int CordicSteps = 16;
	localparam int CntW        = 5;
	localparam int DivBits     = 15;
	localparam int XyW         = 64;
	localparam int ZW          = 35;
	localparam int NumW        = 55;
	localparam int CfgIdxW     = 2;

	localparam logic [CfgIdxW-1:0] CfgMinStep  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgGateWin  = 2'd1;

	localparam logic signed [ZW-1:0] PiQ30   = 35'sd3373259426;
	localparam logic [19:0]          ConvNum = 20'd900000;
	localparam logic [37:0]          ConvDen = 38'd168577466368;

	// ConvDen = 157 * 2^RecipSh: drop the low RecipSh bits, then divide by 157
	// as a multiply by ceil(2^30 / 157), exact for numerators below 2^26
	localparam int               RecipSh  = 30;
	localparam int               RecipW   = 23;
	localparam logic [RecipW-1:0] RecipDiv = 23'd6839120;

	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_CORD, S_MUL, S_DIV, S_FIN
	} gpsh_state_t;

	typedef struct packed {
		logic            load;
		logic            init;
		logic            cord;
		logic            mul;
		logic            div;
		logic            fin;
		logic [CntW-1:0] cnt;
	} gpsh_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} gpsh_sts_t;

	// atan(2^-i) in radians * 2^30, truncated
	function automatic logic [29:0] atan_q30(input logic [CntW-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

### hw/rtl/gpsh_chan_if.sv
// ----------------------------------------------------------------------------
// gpsh channel interfaces
// Valid/ready channels for GPS fixes and heading results.
// ----------------------------------------------------------------------------
`default_nettype none
interface gpsh_fix_if;
	logic        valid;
	logic        ready;
	logic [29:0] easting_mm;
	logic [33:0] northing_mm;
	logic [47:0] time_us;
	modport source (output valid, easting_mm, northing_mm, time_us, input ready);
	modport sink (input valid, easting_mm, northing_mm, time_us, output ready);
endinterface

interface gpsh_res_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] pos_x_mm;
	logic signed [34:0] pos_y_mm;
	logic signed [15:0] heading_cdeg;
	logic [47:0]        dt_held_us;
	logic               updated;
	logic               backward_seen;
	modport source (output valid, pos_x_mm, pos_y_mm, heading_cdeg, dt_held_us,
		updated, backward_seen, input ready);
	modport sink (input valid, pos_x_mm, pos_y_mm, heading_cdeg, dt_held_us,
		updated, backward_seen, output ready);
endinterface
`default_nettype wire

### hw/rtl/gps_heading_estimator_top.sv
// From fix accepted to result valid: init, 16 CORDIC iterations, one scaling
// multiply, one reciprocal divide multiply, then finish (held while the output is busy).
// A fix is taken only while idle, so a new fix waits until the last one has finished.
// The result register lets the next fix enter while a result waits.
// Reset (arst_n low) clears origin, held heading, dt, flags and out_valid; datapath registers are not reset.
// ----------------------------------------------------------------------------
// gps_heading_estimator_top
// GPS fix to local position and gated heading estimate.
// ----------------------------------------------------------------------------
`default_nettype none
module gps_heading_estimator_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	gpsh_fix_if.sink                          fix,
	gpsh_res_if.source                        res,
	input  wire logic                         cfg_we,
	input  wire logic [gpsh_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [15:0]                  cfg_wdata
);
	gpsh_pkg::gpsh_cmd_t cmd;
	gpsh_pkg::gpsh_sts_t sts;

	gpsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.in_ready (fix.ready),
		.cmd      (cmd)
	);

	gpsh_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_valid      (fix.valid),
		.easting_mm    (fix.easting_mm),
		.northing_mm   (fix.northing_mm),
		.time_us       (fix.time_us),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.pos_x_mm      (res.pos_x_mm),
		.pos_y_mm      (res.pos_y_mm),
		.heading_cdeg  (res.heading_cdeg),
		.dt_held_us    (res.dt_held_us),
		.updated       (res.updated),
		.backward_seen (res.backward_seen)
	);
endmodule
`default_nettype wire

### hw/rtl/gpsh_ctrl.sv
// ----------------------------------------------------------------------------
// gpsh_ctrl
// Sequencer: load, init, CORDIC iterations, scaling multiply, divide, finish.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gps_heading_estimator_top_defines.svh"
module gpsh_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gpsh_pkg::gpsh_sts_t sts,
	output logic                    in_ready,
	output gpsh_pkg::gpsh_cmd_t     cmd
);
	gpsh_pkg::gpsh_state_t state_q, state_d;
	logic [gpsh_pkg::CntW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpsh_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.cnt  = cnt_q;
		case (state_q)
			gpsh_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load = 1'b1;
					state_d  = gpsh_pkg::S_INIT;
				end
			end
			gpsh_pkg::S_INIT: begin
				cmd.init = 1'b1;
				cnt_d    = '0;
				state_d  = gpsh_pkg::S_CORD;
			end
			gpsh_pkg::S_CORD: begin
				cmd.cord = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == gpsh_pkg::CntW'(gpsh_pkg::CordicSteps - 1))
					state_d = gpsh_pkg::S_MUL;
			end
			gpsh_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = '0;
				state_d = gpsh_pkg::S_DIV;
			end
			gpsh_pkg::S_DIV: begin
				cmd.div = 1'b1;
				state_d = gpsh_pkg::S_FIN;
			end
			gpsh_pkg::S_FIN: begin
				// hold until the output register can take the beat
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					state_d = gpsh_pkg::S_IDLE;
				end
			end
			default: state_d = gpsh_pkg::S_IDLE;
		endcase
	end

	`GPSH_CHECK(a_load_to_init, clk, arst_n, cmd.load |=> state_q == gpsh_pkg::S_INIT)
	`GPSH_CHECK(a_cord_len, clk, arst_n, (state_q == gpsh_pkg::S_CORD && cnt_q == gpsh_pkg::CntW'(gpsh_pkg::CordicSteps - 1)) |=> state_q == gpsh_pkg::S_MUL)
	`GPSH_CHECK(a_fin_done, clk, arst_n, cmd.fin |=> (state_q == gpsh_pkg::S_IDLE && !$past(sts.out_busy)))
	`GPSH_CHECK_ALWAYS(a_cmd_onehot, clk, $onehot0({cmd.load, cmd.init, cmd.cord, cmd.mul, cmd.div, cmd.fin}))
endmodule
`default_nettype wire

### hw/rtl/gpsh_dp.sv
// ----------------------------------------------------------------------------
// gpsh_dp
// Local position, CORDIC atan2, centidegree scaling, gate and held state.
// ----------------------------------------------------------------------------
`default_nettype none
module gpsh_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gpsh_pkg::gpsh_cmd_t          cmd,
	output gpsh_pkg::gpsh_sts_t               sts,
	input  wire logic                         in_valid,
	input  wire logic [29:0]                  easting_mm,
	input  wire logic [33:0]                  northing_mm,
	input  wire logic [47:0]                  time_us,
	input  wire logic                         cfg_we,
	input  wire logic [gpsh_pkg::CfgIdxW-1:0] cfg_idx,
	input  wire logic [15:0]                  cfg_wdata,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [30:0]                pos_x_mm,
	output logic signed [34:0]                pos_y_mm,
	output logic signed [15:0]                heading_cdeg,
	output logic [47:0]                       dt_held_us,
	output logic                              updated,
	output logic                              backward_seen
);
	localparam int XyW  = gpsh_pkg::XyW;
	localparam int ZW   = gpsh_pkg::ZW;
	localparam int RemW = gpsh_pkg::NumW - gpsh_pkg::RecipSh;
	localparam int PrdW = RemW + gpsh_pkg::RecipW;

	logic [15:0] min_step_q;
	logic [14:0] gate_win_q;
	logic        origin_set_q;
	logic [29:0] origin_east_q;
	logic [33:0] origin_north_q;
	logic signed [30:0] last_x_q;
	logic signed [34:0] last_y_q;
	logic [47:0] last_time_q;
	logic signed [15:0] held_heading_q;
	logic [47:0] held_dt_q;
	logic        backward_q;

	logic signed [30:0] x_q;
	logic signed [34:0] y_q;
	logic signed [31:0] dx_q;
	logic signed [35:0] dy_q;
	logic [47:0] dt_q;

	logic signed [XyW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0]  cz_q;
	logic zero_q, step_ok_q, zneg_q;
	logic [RemW-1:0] rem_q;
	logic [gpsh_pkg::DivBits-1:0] quo_q;

	logic out_valid_q;
	logic signed [30:0] out_x_q;
	logic signed [34:0] out_y_q;
	logic signed [15:0] out_head_q;
	logic [47:0] out_dt_q;
	logic out_upd_q, out_back_q;

	// load stage
	logic [29:0] e0_sel;
	logic [33:0] n0_sel;
	logic [47:0] t_last_sel;
	logic signed [30:0] x_new;
	logic signed [34:0] y_new;
	assign e0_sel     = origin_set_q ? origin_east_q : easting_mm;
	assign n0_sel     = origin_set_q ? origin_north_q : northing_mm;
	assign t_last_sel = origin_set_q ? last_time_q : time_us;
	assign x_new = $signed({1'b0, easting_mm}) - $signed({1'b0, e0_sel});
	assign y_new = $signed({1'b0, n0_sel}) - $signed({1'b0, northing_mm});

	// init stage: CORDIC on (-dy, dx), scaled by 2^20
	logic signed [XyW-1:0] xv_s, yv_s;
	logic dy_pos;
	assign xv_s   = (-XyW'(dy_q)) <<< 20;
	assign yv_s   = XyW'(dx_q) <<< 20;
	assign dy_pos = (dy_q > 36'sd0);

	// CORDIC step
	logic signed [XyW-1:0] xsh, ysh;
	logic signed [ZW-1:0]  atan_z;
	assign xsh    = cx_q >>> cmd.cnt;
	assign ysh    = cy_q >>> cmd.cnt;
	assign atan_z = ZW'(gpsh_pkg::atan_q30(cmd.cnt));

	// scaling
	logic [ZW-2:0] zmag;
	assign zmag = cz_q[ZW-1] ? (ZW-1)'(-cz_q) : cz_q[ZW-2:0];

	// rounded divide by ConvDen: shift out 2^30, then reciprocal multiply by 1/157
	logic [gpsh_pkg::NumW-1:0] num_full;
	logic [PrdW-1:0]           div_prod;
	assign num_full = gpsh_pkg::NumW'(zmag * gpsh_pkg::ConvNum)
		+ gpsh_pkg::NumW'(gpsh_pkg::ConvDen >> 1);
	assign div_prod = PrdW'(rem_q) * PrdW'(gpsh_pkg::RecipDiv);

	// gate
	logic signed [15:0] theta;
	logic signed [17:0] diff_raw, diff, back_raw, back, mx;
	logic fwd_ok, back_ok, upd;
	always_comb begin
		if (zero_q)
			theta = '0;
		else if (zneg_q)
			theta = -$signed({1'b0, quo_q});
		else
			theta = $signed({1'b0, quo_q});
		mx       = $signed({3'b0, gate_win_q});
		diff_raw = 18'(held_heading_q) - 18'(theta);
		diff     = diff_raw[17] ? -diff_raw : diff_raw;
		back_raw = diff - 18'sd18000;
		back     = back_raw[17] ? -back_raw : back_raw;
		fwd_ok   = (diff < mx) || (diff > (18'sd36000 - mx));
		back_ok  = back < mx;
		upd      = step_ok_q && (fwd_ok || back_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_step_q     <= 16'd250;
			gate_win_q     <= 15'd4000;
			origin_set_q   <= 1'b0;
			origin_east_q  <= '0;
			origin_north_q <= '0;
			last_x_q       <= '0;
			last_y_q       <= '0;
			last_time_q    <= '0;
			held_heading_q <= '0;
			held_dt_q      <= '0;
			backward_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					gpsh_pkg::CfgMinStep: min_step_q <= cfg_wdata;
					gpsh_pkg::CfgGateWin: gate_win_q <= cfg_wdata[14:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				origin_set_q   <= 1'b1;
				origin_east_q  <= e0_sel;
				origin_north_q <= n0_sel;
				last_x_q       <= x_new;
				last_y_q       <= y_new;
				last_time_q    <= time_us;
			end
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.fin) begin
				if (upd) begin
					held_heading_q <= theta;
					held_dt_q      <= dt_q;
					if (!fwd_ok)
						backward_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= x_new;
			y_q  <= y_new;
			dx_q <= 32'(x_new) - 32'(last_x_q);
			dy_q <= 36'(y_new) - 36'(last_y_q);
			dt_q <= time_us - t_last_sel;
		end
		if (cmd.init) begin
			zero_q    <= (dx_q == '0) && (dy_q == '0);
			step_ok_q <= (dt_q != '0) && ((dx_q > $signed({16'b0, min_step_q}))
				|| (dy_q > $signed({20'b0, min_step_q})));
			if (dy_pos) begin
				cx_q <= -xv_s;
				cy_q <= -yv_s;
				cz_q <= (dx_q >= 32'sd0) ? gpsh_pkg::PiQ30 : -gpsh_pkg::PiQ30;
			end else begin
				cx_q <= xv_s;
				cy_q <= yv_s;
				cz_q <= '0;
			end
		end
		if (cmd.cord) begin
			if (!cy_q[XyW-1]) begin
				cx_q <= cx_q + ysh;
				cy_q <= cy_q - xsh;
				cz_q <= cz_q + atan_z;
			end else begin
				cx_q <= cx_q - ysh;
				cy_q <= cy_q + xsh;
				cz_q <= cz_q - atan_z;
			end
		end
		if (cmd.mul) begin
			rem_q  <= num_full[gpsh_pkg::NumW-1:gpsh_pkg::RecipSh];
			zneg_q <= cz_q[ZW-1];
		end
		if (cmd.div)
			quo_q <= div_prod[gpsh_pkg::RecipSh +: gpsh_pkg::DivBits];
		if (cmd.fin) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_head_q <= upd ? theta : held_heading_q;
			out_dt_q   <= upd ? dt_q : held_dt_q;
			out_upd_q  <= upd;
			out_back_q <= backward_q || (upd && !fwd_ok);
		end
	end

	assign sts.in_valid  = in_valid;
	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign pos_x_mm      = out_x_q;
	assign pos_y_mm      = out_y_q;
	assign heading_cdeg  = out_head_q;
	assign dt_held_us    = out_dt_q;
	assign updated       = out_upd_q;
	assign backward_seen = out_back_q;
endmodule
`default_nettype wire
